FILE: design/gcme_pkg.sv
package gcme_pkg;

    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int TIME_W   = 32;
    localparam int RANGE_W  = 16;
    localparam int DIVD_W   = 25;
    localparam int DIVS_W   = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] FN_MERGE = 2'd0;
    localparam logic [1:0] FN_RANGE = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    localparam logic [2:0] M_MIN     = 3'd0;
    localparam logic [2:0] M_MAX     = 3'd1;
    localparam logic [2:0] M_MEAN    = 3'd2;
    localparam logic [2:0] M_SUM     = 3'd3;
    localparam logic [2:0] M_LATEST  = 3'd4;
    localparam logic [2:0] M_CLOSEST = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_MISS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_BAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MISS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_MISS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HI = 3'd6;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 16'hFFFF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
        logic [RANGE_W-1:0] range;
        logic               flag;
    } gcme_entry_t;

    localparam int ENTRY_W = $bits(gcme_entry_t);

endpackage

FILE: design/gcme_ifs.sv
interface gcme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] cell_index;
    logic [15:0] sample;
    logic [31:0] sample_time;
    logic [15:0] source_range;
    modport source (output valid, func, cell_index, sample, sample_time, source_range,
                    input ready);
    modport sink (input valid, func, cell_index, sample, sample_time, source_range,
                  output ready);
endinterface

interface gcme_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [7:0]  cell_count;
    logic        cell_closest;
    logic        cell_was_updated;
    modport source (output valid, cell_value, cell_count, cell_closest, cell_was_updated,
                    input ready);
    modport sink (input valid, cell_value, cell_count, cell_closest, cell_was_updated,
                  output ready);
endinterface

interface gcme_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gcme_ram.sv
module gcme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/gcme_div.sv
module gcme_div
    import gcme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        trial     = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/grid_cell_merge_engine_unit.sv
// Grid cell merge engine. Every input transfer addresses one cell of an on-chip store of
// GRID_CELLS entries and returns exactly one result transfer with the cell's state after
// the operation. After reset a clearing pass writes every entry, one per cycle; input is
// not accepted during it while configuration writes are. An item then passes through
// read, evaluate and write; a running-mean merge into a non-empty cell whose count is
// below COUNT_MAX also runs the shared restoring divider, which produces one quotient
// bit per cycle over 25 bits. Out-of-range cell indexes skip read and evaluate.
// The store has one read and one write port, so one item is in flight at a time; a
// finished result waits in the output register while the next item is accepted.
module grid_cell_merge_engine_unit
    import gcme_pkg::*;
#(
    parameter int GRID_CELLS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    gcme_in_if.sink     in_ch,
    gcme_out_if.source  out_ch,
    gcme_cfg_if.sink    cfg
);

    localparam int ADDR_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [2:0]  method_reg;
    logic [15:0] in_miss_reg, in_bad_reg, out_miss_reg, rng_miss_reg;
    logic [15:0] clamp_lo_reg, clamp_hi_reg;

    logic [1:0]  func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [15:0] smp_reg;
    logic [31:0] time_reg;
    logic [15:0] rng_reg;
    logic        oob_reg;

    gcme_entry_t rd_entry, new_reg, ne;
    logic [15:0] before_reg;
    logic [23:0] num_reg;
    logic [8:0]  den_reg;
    logic        mean_go;

    logic        ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    gcme_entry_t ram_wdata;

    logic        div_done;
    logic [DIVD_W-1:0] div_q;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic [7:0]  out_count_reg;
    logic        out_flag_reg;
    logic        out_upd_reg;
    logic        out_free;

    logic        accept;
    logic        empty, skip;
    logic [23:0] idx_ext;

    function automatic logic [15:0] clamp_val(input logic [DIVD_W-1:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [DIVD_W-1:0] t;
        t = v;
        if (t > DIVD_W'(hi))
        begin
            t = DIVD_W'(hi);
        end
        if (t < DIVD_W'(lo))
        begin
            t = DIVD_W'(lo);
        end
        return t[15:0];
    endfunction

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign idx_ext      = 24'(in_ch.cell_index);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg   <= M_MIN;
            in_miss_reg  <= '0;
            in_bad_reg   <= '0;
            out_miss_reg <= '0;
            rng_miss_reg <= 16'hFFFF;
            clamp_lo_reg <= 16'd20;
            clamp_hi_reg <= 16'hFFFF;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_METHOD:   method_reg   <= cfg.data[2:0];
                CFG_IN_MISS:  in_miss_reg  <= cfg.data;
                CFG_IN_BAD:   in_bad_reg   <= cfg.data;
                CFG_OUT_MISS: out_miss_reg <= cfg.data;
                CFG_RNG_MISS: rng_miss_reg <= cfg.data;
                CFG_CLAMP_LO: clamp_lo_reg <= cfg.data;
                CFG_CLAMP_HI: clamp_hi_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // cell store
    gcme_ram #(.WIDTH(ENTRY_W), .DEPTH(GRID_CELLS), .AW(ADDR_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = new_reg;
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '{value: '0, count: '0, stamp: '0, range: RANGE_RESET, flag: 1'b0};
        end
        else if (state_reg == S_WR)
        begin
            ram_we = !oob_reg;
        end
    end

    // shared divider for the running mean
    gcme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DST),
        .dividend ({num_reg, 1'b0} + DIVD_W'(den_reg)),
        .divisor  ({den_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    // evaluate the operation on the entry just read
    always_comb
    begin
        empty   = (rd_entry.value == out_miss_reg);
        skip    = (smp_reg == in_miss_reg) || (smp_reg == in_bad_reg);
        ne      = rd_entry;
        mean_go = 1'b0;
        case (func_reg)
            FN_MERGE:
            begin
                if (method_reg == M_CLOSEST)
                begin
                    if (rd_entry.flag)
                    begin
                        ne.value = skip ? out_miss_reg : smp_reg;
                    end
                end
                else if (!skip)
                begin
                    case (method_reg)
                        M_MIN:
                            if (empty || smp_reg < rd_entry.value) ne.value = smp_reg;
                        M_MAX:
                            if (empty || smp_reg > rd_entry.value) ne.value = smp_reg;
                        M_MEAN:
                            if (empty)
                            begin
                                ne.value = smp_reg;
                                ne.count = 8'd1;
                            end
                            else if (rd_entry.count != COUNT_MAX)
                            begin
                                mean_go = 1'b1;
                            end
                        M_SUM:
                            ne.value = empty ? smp_reg :
                                clamp_val(DIVD_W'(rd_entry.value) + DIVD_W'(smp_reg),
                                          clamp_lo_reg, clamp_hi_reg);
                        M_LATEST:
                            if (empty || time_reg > rd_entry.stamp)
                            begin
                                ne.value = smp_reg;
                                ne.stamp = time_reg;
                            end
                        default: ;
                    endcase
                end
            end
            FN_RANGE:
            begin
                if (rng_reg != rng_miss_reg && rng_reg < rd_entry.range)
                begin
                    ne.range = rng_reg;
                    ne.flag  = 1'b1;
                end
            end
            FN_READ: ;
            default:
            begin
                ne = '{value: out_miss_reg, count: '0, stamp: '0, range: RANGE_RESET,
                       flag: 1'b0};
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == ADDR_W'(GRID_CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    state_next = (32'(in_ch.cell_index) >= GRID_CELLS) ? S_WR : S_RD;
                end
            S_RD:   state_next = S_EX;
            S_EX:   state_next = mean_go ? S_DST : S_WR;
            S_DST:  state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_WR;
            S_WR:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // item and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= in_ch.func;
            addr_reg <= idx_ext[ADDR_W-1:0];
            smp_reg  <= in_ch.sample;
            time_reg <= in_ch.sample_time;
            rng_reg  <= in_ch.source_range;
            oob_reg  <= (32'(in_ch.cell_index) >= GRID_CELLS);
            new_reg  <= '0;
            before_reg <= '0;
        end
        else if (state_reg == S_EX)
        begin
            new_reg    <= ne;
            before_reg <= rd_entry.value;
            num_reg    <= 24'(rd_entry.value) * 24'(rd_entry.count) + 24'(smp_reg);
            den_reg    <= 9'(rd_entry.count) + 9'd1;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            new_reg.value <= clamp_val(div_q, clamp_lo_reg, clamp_hi_reg);
            new_reg.count <= new_reg.count + COUNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_WR && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR && out_free)
        begin
            out_value_reg <= new_reg.value;
            out_count_reg <= new_reg.count;
            out_flag_reg  <= new_reg.flag;
            out_upd_reg   <= (new_reg.value != before_reg);
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.cell_value       = out_value_reg;
    assign out_ch.cell_count       = out_count_reg;
    assign out_ch.cell_closest     = out_flag_reg;
    assign out_ch.cell_was_updated = out_upd_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ch.ready)
        else $error("input accepted during clearing pass");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RD || state_reg == S_WR))
        else $error("accepted item not sequenced");

    a_no_oob_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && oob_reg) |-> !ram_we)
        else $error("store written for out-of-range index");

endmodule

FILE: test/tb_top.sv
module tb_top
    import gcme_pkg::*;
();

    localparam int  CELLS      = 65536;
    localparam int  CYCLE_CAP  = 1500000;
    localparam logic [2:0] M_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  count;
        logic        closest;
        logic        updated;
    } cell_result_t;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] cell_index;
        logic [15:0] sample;
        logic [31:0] sample_time;
        logic [15:0] source_range;
        bit          has_fixed;
        cell_result_t fixed;
    } stim_row_t;

    logic clk;
    logic rst_n;

    gcme_in_if  in_ch ();
    gcme_out_if out_ch ();
    gcme_cfg_if cfg ();

    grid_cell_merge_engine_unit #(.GRID_CELLS(CELLS)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // shadow copy of the grid store and registers
    logic [15:0] grid_value [CELLS];
    logic [7:0]  grid_count [CELLS];
    logic [31:0] grid_stamp [CELLS];
    logic [15:0] grid_range [CELLS];
    logic        grid_flag  [CELLS];

    logic [2:0]  r_method;
    logic [15:0] r_in_miss, r_in_bad, r_out_miss, r_rng_miss, r_lo, r_hi;

    cell_result_t pending_cells [$];
    int           error_count;
    int           cycle_count = 0;
    stim_row_t    rows [$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic [15:0] clamp_mean_sum(input logic [31:0] v);
        logic [31:0] c;
        c = v;
        if (c > r_hi) c = r_hi;
        if (c < r_lo) c = r_lo;
        return c[15:0];
    endfunction

    // compute the cell state after one item
    function automatic cell_result_t merge_cell(input logic [1:0] fn, input logic [15:0] idx,
                                                input logic [15:0] smp, input logic [31:0] t,
                                                input logic [15:0] rng);
        cell_result_t r;
        logic [15:0] prior, cur;
        logic        empty, skip;
        logic [31:0] num, den, n;
        prior = grid_value[idx];
        cur   = prior;
        empty = (cur == r_out_miss);
        skip  = (smp == r_in_miss) || (smp == r_in_bad);
        case (fn)
            FN_MERGE:
            begin
                if (r_method == M_CLOSEST)
                begin
                    if (grid_flag[idx]) grid_value[idx] = skip ? r_out_miss : smp;
                end
                else if (!skip)
                begin
                    case (r_method)
                        M_MIN: grid_value[idx] = (empty || smp < cur) ? smp : cur;
                        M_MAX: grid_value[idx] = (empty || smp > cur) ? smp : cur;
                        M_MEAN:
                        begin
                            if (empty)
                            begin
                                grid_value[idx] = smp;
                                grid_count[idx] = 8'd1;
                            end
                            else if (grid_count[idx] < COUNT_MAX)
                            begin
                                n   = grid_count[idx];
                                num = cur * n + smp;
                                den = n + 1;
                                grid_value[idx] = clamp_mean_sum((2 * num + den) / (2 * den));
                                grid_count[idx] = grid_count[idx] + 8'd1;
                            end
                        end
                        M_SUM: grid_value[idx] = empty ? smp
                                               : clamp_mean_sum({16'd0, cur} + smp);
                        M_LATEST:
                        begin
                            if (empty || t > grid_stamp[idx])
                            begin
                                grid_value[idx] = smp;
                                grid_stamp[idx] = t;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FN_RANGE:
            begin
                if (rng != r_rng_miss && rng < grid_range[idx])
                begin
                    grid_range[idx] = rng;
                    grid_flag[idx]  = 1'b1;
                end
            end
            FN_READ: ;
            default:
            begin
                grid_value[idx] = r_out_miss;
                grid_count[idx] = 8'd0;
                grid_stamp[idx] = 32'd0;
                grid_range[idx] = RANGE_RESET;
                grid_flag[idx]  = 1'b0;
            end
        endcase
        r.value   = grid_value[idx];
        r.count   = grid_count[idx];
        r.closest = grid_flag[idx];
        r.updated = (grid_value[idx] != prior);
        return r;
    endfunction

    // write one register, then leave the channel idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            CFG_METHOD:   r_method   = data[2:0];
            CFG_IN_MISS:  r_in_miss  = data;
            CFG_IN_BAD:   r_in_bad   = data;
            CFG_OUT_MISS: r_out_miss = data;
            CFG_RNG_MISS: r_rng_miss = data;
            CFG_CLAMP_LO: r_lo       = data;
            CFG_CLAMP_HI: r_hi       = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_row(input stim_row_t s);
        rows.insert(rows.size(), s);
    endtask

    // send one item, queue its prediction or the typed-in result
    task automatic send_item(input stim_row_t s);
        cell_result_t want;
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= s.func;
        in_ch.cell_index   <= s.cell_index;
        in_ch.sample       <= s.sample;
        in_ch.sample_time  <= s.sample_time;
        in_ch.source_range <= s.source_range;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        want = merge_cell(s.func, s.cell_index, s.sample, s.sample_time, s.source_range);
        if (s.has_fixed && want != s.fixed)
            report_mismatch("typed-in row vs predictor", int'(want), int'(s.fixed));
        pending_cells.insert(pending_cells.size(), s.has_fixed ? s.fixed : want);
        @(negedge clk);
    endtask

    // drop valid, then hold until every expected result has come
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic stim_row_t mk(input logic [1:0] f, input logic [15:0] i,
                                     input logic [15:0] s, input logic [31:0] t,
                                     input logic [15:0] r);
        stim_row_t x;
        x.func = f; x.cell_index = i; x.sample = s; x.sample_time = t;
        x.source_range = r; x.has_fixed = 0; x.fixed = '0;
        return x;
    endfunction

    function automatic stim_row_t mkf(input logic [1:0] f, input logic [15:0] i,
                                      input logic [15:0] s, input cell_result_t w);
        stim_row_t x;
        x = mk(f, i, s, 32'd0, 16'd0);
        x.has_fixed = 1;
        x.fixed = w;
        return x;
    endfunction

    // random item over a small pool of cells so merges build on each other
    function automatic stim_row_t rand_item();
        stim_row_t x;
        int k;
        k = $urandom_range(0, 99);
        x = mk(FN_MERGE, 16'($urandom_range(0, 15)), 16'($urandom), $urandom, 16'($urandom));
        if (k < 8) x.cell_index = 16'($urandom);
        if (k < 60) x.func = FN_MERGE;
        else if (k < 78) x.func = FN_RANGE;
        else if (k < 92) x.func = FN_READ;
        else x.func = FN_CLEAR;
        case ($urandom_range(0, 9))
            0: x.sample = r_in_miss;
            1: x.sample = r_in_bad;
            2: x.sample = 16'($urandom_range(0, 300));
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) x.source_range = r_rng_miss;
        if ($urandom_range(0, 3) == 0) x.sample_time = $urandom_range(0, 50);
        return x;
    endfunction

    // sink side: random stall, compare the oldest expectation
    initial
    begin
        cell_result_t want;
        int gap;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && rst_n)) @(posedge clk);
            if (pending_cells.size() == 0)
                report_mismatch("unexpected result", out_ch.cell_value, 0);
            else
            begin
                want = pending_cells.pop_front();
                if (out_ch.cell_value != want.value)
                    report_mismatch("cell_value", out_ch.cell_value, want.value);
                if (out_ch.cell_count != want.count)
                    report_mismatch("cell_count", out_ch.cell_count, want.count);
                if (out_ch.cell_closest != want.closest)
                    report_mismatch("cell_closest", out_ch.cell_closest, want.closest);
                if (out_ch.cell_was_updated != want.updated)
                    report_mismatch("cell_was_updated", out_ch.cell_was_updated,
                                    want.updated);
            end
        end
    end

    // stimulus
    initial
    begin
        int m;
        error_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = '0; in_ch.cell_index = '0; in_ch.sample = '0;
        in_ch.sample_time = '0; in_ch.source_range = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            grid_value[i] = 16'd0; grid_count[i] = 8'd0; grid_stamp[i] = 32'd0;
            grid_range[i] = RANGE_RESET; grid_flag[i] = 1'b0;
        end
        r_method = M_MIN; r_in_miss = 16'd0; r_in_bad = 16'd0; r_out_miss = 16'd0;
        r_rng_miss = 16'hFFFF; r_lo = 16'd20; r_hi = 16'hFFFF;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed table under reset settings, then max/mean/sum/latest/closest and an unused method
        add_row(mkf(FN_READ, 16'd0, 16'd0, '{16'd0, 8'd0, 1'b0, 1'b0}));
        add_row(mkf(FN_READ, 16'hFFFF, 16'd0, '{16'd0, 8'd0, 1'b0, 1'b0}));
        add_row(mkf(FN_MERGE, 16'd1, 16'd0, '{16'd0, 8'd0, 1'b0, 1'b0}));
        add_row(mkf(FN_MERGE, 16'd1, 16'hFFFF, '{16'hFFFF, 8'd0, 1'b0, 1'b1}));
        add_row(mk(FN_MERGE, 16'd1, 16'd7, 32'd0, 16'd0));
        add_row(mk(FN_RANGE, 16'd1, 16'd0, 32'd0, 16'hFFFF));
        add_row(mkf(FN_CLEAR, 16'd1, 16'd0, '{16'd0, 8'd0, 1'b0, 1'b1}));
        add_row(mk(FN_RANGE, 16'hFFFF, 16'd0, 32'd0, 16'd0));
        foreach (rows[i]) send_item(rows[i]);
        rows.delete();
        drain_results();
        write_reg(CFG_METHOD, 16'(M_MAX));
        send_item(mk(FN_MERGE, 16'd2, 16'd5, 32'd0, 16'd0));
        send_item(mk(FN_MERGE, 16'd2, 16'd3, 32'd0, 16'd0));
        drain_results();
        write_reg(CFG_METHOD, 16'(M_MEAN));
        write_reg(CFG_IN_MISS, 16'hFFFF);
        write_reg(CFG_IN_BAD, 16'hFFFE);
        write_reg(CFG_OUT_MISS, 16'hFFFF);
        send_item(mk(FN_CLEAR, 16'd3, 0, 0, 0));
        for (int i = 0; i < 258; i++)
            send_item(mk(FN_MERGE, 16'd3, (i % 2) ? 16'hFFFD : 16'd0, 0, 0));
        send_item(mk(FN_MERGE, 16'd3, 16'hFFFE, 0, 0));
        drain_results();
        write_reg(CFG_METHOD, 16'(M_SUM));
        write_reg(CFG_CLAMP_HI, 16'd1000);
        send_item(mk(FN_CLEAR, 16'd4, 0, 0, 0));
        send_item(mk(FN_MERGE, 16'd4, 16'd900, 0, 0));
        send_item(mk(FN_MERGE, 16'd4, 16'd900, 0, 0));
        drain_results();
        write_reg(CFG_METHOD, 16'(M_LATEST));
        send_item(mk(FN_MERGE, 16'd4, 16'd11, 32'hFFFFFFFF, 0));
        send_item(mk(FN_MERGE, 16'd4, 16'd12, 32'd5, 0));
        drain_results();
        write_reg(CFG_METHOD, 16'(M_CLOSEST));
        write_reg(CFG_RNG_MISS, 16'd0);
        send_item(mk(FN_MERGE, 16'd5, 16'd9, 0, 0));
        send_item(mk(FN_RANGE, 16'd5, 0, 0, 16'd0));
        send_item(mk(FN_RANGE, 16'd5, 0, 0, 16'd100));
        send_item(mk(FN_MERGE, 16'd5, 16'd9, 0, 0));
        send_item(mk(FN_MERGE, 16'd5, 16'hFFFF, 0, 0));
        drain_results();
        write_reg(CFG_METHOD, 16'(M_UNUSED));
        send_item(mk(FN_MERGE, 16'd6, 16'd9, 0, 0));
        drain_results();

        // random phases with varying settings, extremes included
        for (int ph = 0; ph < 14; ph++)
        begin
            m = ph % 8;
            write_reg(CFG_METHOD, 16'(m[2:0]));
            write_reg(CFG_IN_MISS, (ph % 3 == 0) ? 16'hFFFF : 16'($urandom_range(0, 300)));
            write_reg(CFG_IN_BAD, (ph % 4 == 1) ? 16'd0 : 16'($urandom));
            write_reg(CFG_OUT_MISS, (ph % 2) ? 16'd0 : 16'hFFFF);
            write_reg(CFG_RNG_MISS, (ph % 3 == 2) ? 16'd0 : 16'($urandom));
            write_reg(CFG_CLAMP_LO, (ph % 5 == 0) ? 16'd0 : 16'($urandom_range(0, 200)));
            write_reg(CFG_CLAMP_HI, (ph % 5 == 1) ? 16'hFFFF : 16'($urandom_range(200, 65535)));
            for (int k = 0; k < 105; k++)
                send_item(rand_item());
            drain_results();
        end

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
